FILE: sv/assert_macros.svh
// ---------------------------------------------------------------------------
// assertion macros
// shared helpers for concurrent checks, compiled out when SYNTH is set
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
`define ASSERT_PROP(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define ASSERT_PROP(label, clk, rst_n, prop, msg)
`define ASSERT_NEVER(label, clk, rst_n, cond, msg)
`endif

`endif

FILE: sv/mmcrc_pkg.sv
// ---------------------------------------------------------------------------
// mmcrc_pkg
// types, codes and helpers of the multi-mode crc checker
// ---------------------------------------------------------------------------
`default_nettype none

package mmcrc_pkg;

  typedef enum logic [1:0] {
    MODE_CRC16_SEEDED = 2'd0,
    MODE_XMODEM       = 2'd1,
    MODE_CRC32        = 2'd2
  } mode_e;

  localparam logic [1:0]  CFG_MODE = 2'd0;
  localparam logic [1:0]  CFG_SEED = 2'd1;

  localparam logic [15:0] POLY16_REFL = 16'h8408;
  localparam logic [15:0] POLY16      = 16'h1021;
  localparam logic [31:0] POLY32_REFL = 32'hEDB88320;
  localparam logic [15:0] XOR16       = 16'hFFFF;
  localparam logic [31:0] XOR32       = 32'hFFFFFFFF;
  localparam logic [15:0] SEED_RESET  = 16'hFFFF;

  // outcome of one byte step
  typedef struct packed {
    logic [31:0] rem_next;
    logic [31:0] finished;
    logic        match;
  } step_res_t;

  function automatic logic [31:0] start_value(input logic [1:0] mode, input logic [15:0] seed);
    logic [31:0] v;
    case (mode)
      MODE_CRC16_SEEDED: v = {16'h0000, seed};
      MODE_XMODEM:       v = 32'h0000_0000;
      default:           v = XOR32;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

FILE: sv/mmcrc_if.sv
// ---------------------------------------------------------------------------
// mmcrc channel interfaces
// valid/ready channels for message bytes and finished crc results
// ---------------------------------------------------------------------------
`default_nettype none

interface mmcrc_in_if;
  logic        valid;
  logic        ready;
  logic [7:0]  data_byte;
  logic        last_byte;
  logic [31:0] crc_check;

  modport source (output valid, data_byte, last_byte, crc_check, input ready);
  modport sink   (input valid, data_byte, last_byte, crc_check, output ready);
endinterface

interface mmcrc_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] crc_result;
  logic        crc_match;

  modport source (output valid, crc_result, crc_match, input ready);
  modport sink   (input valid, crc_result, crc_match, output ready);
endinterface

`default_nettype wire

FILE: sv/mmcrc_step.sv
// ---------------------------------------------------------------------------
// mmcrc_step
// one-byte crc update for all three modes, plus final xor (where the mode has one) and compare
// ---------------------------------------------------------------------------
`default_nettype none

module mmcrc_step (
  input  wire logic [1:0]       mode_i,
  input  wire logic [31:0]      rem_i,
  input  wire logic [7:0]       data_byte_i,
  input  wire logic [31:0]      crc_check_i,
  output mmcrc_pkg::step_res_t  res_o
);

  logic [15:0] r16;
  logic [31:0] r32;
  logic [31:0] expected;

  always_comb begin
    r16      = 16'h0000;
    r32      = 32'h0000_0000;
    expected = crc_check_i;
    res_o    = '0;
    case (mode_i)
      mmcrc_pkg::MODE_CRC16_SEEDED: begin
        r16 = rem_i[15:0] ^ {8'h00, data_byte_i};
        for (int i = 0; i < 8; i++) begin
          r16 = (r16 >> 1) ^ (r16[0] ? mmcrc_pkg::POLY16_REFL : 16'h0000);
        end
        res_o.rem_next = {16'h0000, r16};
        res_o.finished = {16'h0000, r16 ^ mmcrc_pkg::XOR16};
        expected       = {16'h0000, crc_check_i[15:0]};
      end
      mmcrc_pkg::MODE_XMODEM: begin
        r16 = rem_i[15:0] ^ {data_byte_i, 8'h00};
        for (int i = 0; i < 8; i++) begin
          r16 = (r16 << 1) ^ (r16[15] ? mmcrc_pkg::POLY16 : 16'h0000);
        end
        res_o.rem_next = {16'h0000, r16};
        res_o.finished = {16'h0000, r16};
        expected       = {16'h0000, crc_check_i[15:0]};
      end
      default: begin
        // unused code 3 runs as crc-32
        r32 = rem_i ^ {24'h000000, data_byte_i};
        for (int i = 0; i < 8; i++) begin
          r32 = (r32 >> 1) ^ (r32[0] ? mmcrc_pkg::POLY32_REFL : 32'h0000_0000);
        end
        res_o.rem_next = r32;
        res_o.finished = r32 ^ mmcrc_pkg::XOR32;
      end
    endcase
    res_o.match = (res_o.finished == expected);
  end

endmodule

`default_nettype wire

FILE: sv/multi_mode_crc_checker_core.sv
// only a last byte yields a result: input stage, then the result register once it is free
// throughput: one byte item per cycle, set by the combinational eight-bit crc update
// in front of the running remainder register; a stalled result holds back only a last byte
// reset: mode 0 (reflected crc-16), seed 0xFFFF, remainder 0xFFFF, no item held
// a mode or seed config write reloads the remainder with the start value of the new settings
// ---------------------------------------------------------------------------
// multi_mode_crc_checker_core
// byte-wise crc-16 (seeded reflected, xmodem) and crc-32 checker
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module multi_mode_crc_checker_core (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  mmcrc_in_if.sink         in_ch,
  mmcrc_out_if.source      out_ch,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [15:0] cfg_wdata_i
);

  logic [1:0]  mode_q, mode_d;
  logic [15:0] seed_q, seed_d;
  logic [31:0] rem_q;

  // input stage
  logic        s1_valid_q;
  logic [7:0]  s1_byte_q;
  logic        s1_last_q;
  logic [31:0] s1_exp_q;

  // result register
  logic        out_valid_q;
  logic [31:0] out_result_q;
  logic        out_match_q;

  logic        out_free;
  logic        s1_adv;
  logic        in_ready;
  logic        in_acc;

  mmcrc_pkg::step_res_t step_res;

  assign out_free = !out_valid_q || out_ch.ready;
  assign s1_adv   = s1_valid_q && (!s1_last_q || out_free);
  assign in_ready = !s1_valid_q || s1_adv;
  assign in_acc   = in_ch.valid && in_ready;

  assign in_ch.ready       = in_ready;
  assign out_ch.valid      = out_valid_q;
  assign out_ch.crc_result = out_result_q;
  assign out_ch.crc_match  = out_match_q;

  always_comb begin
    mode_d = mode_q;
    seed_d = seed_q;
    if (cfg_we_i && cfg_index_i == mmcrc_pkg::CFG_MODE) begin
      mode_d = cfg_wdata_i[1:0];
    end
    if (cfg_we_i && cfg_index_i == mmcrc_pkg::CFG_SEED) begin
      seed_d = cfg_wdata_i;
    end
  end

  mmcrc_step u_step (
    .mode_i      (mode_q),
    .rem_i       (rem_q),
    .data_byte_i (s1_byte_q),
    .crc_check_i (s1_exp_q),
    .res_o       (step_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= mmcrc_pkg::MODE_CRC16_SEEDED;
      seed_q <= mmcrc_pkg::SEED_RESET;
      rem_q  <= mmcrc_pkg::start_value(mmcrc_pkg::MODE_CRC16_SEEDED, mmcrc_pkg::SEED_RESET);
    end else begin
      mode_q <= mode_d;
      seed_q <= seed_d;
      if (cfg_we_i && (cfg_index_i == mmcrc_pkg::CFG_MODE ||
                       cfg_index_i == mmcrc_pkg::CFG_SEED)) begin
        rem_q <= mmcrc_pkg::start_value(mode_d, seed_d);
      end else if (s1_adv) begin
        // a finished message reloads the start value for the next one
        rem_q <= s1_last_q ? mmcrc_pkg::start_value(mode_q, seed_q) : step_res.rem_next;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready) begin
      s1_valid_q <= in_ch.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_byte_q <= in_ch.data_byte;
      s1_last_q <= in_ch.last_byte;
      s1_exp_q  <= in_ch.crc_check;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= s1_valid_q && s1_last_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free && s1_valid_q && s1_last_q) begin
      out_result_q <= step_res.finished;
      out_match_q  <= step_res.match;
    end
  end

  `ASSERT_PROP(a_out_from_last, clk_i, rst_ni,
               $rose(out_valid_q) |-> $past(s1_valid_q && s1_last_q),
               "result without a last byte")
  `ASSERT_PROP(a_s1_hold, clk_i, rst_ni, (s1_valid_q && !s1_adv) |=> s1_valid_q,
               "held item lost")
  `ASSERT_PROP(a_ready_empty, clk_i, rst_ni, !s1_valid_q |-> in_ready, "empty stage not ready")
  `ASSERT_NEVER(a_crc16_upper, clk_i, rst_ni,
                out_valid_q && (mode_q == mmcrc_pkg::MODE_CRC16_SEEDED ||
                                mode_q == mmcrc_pkg::MODE_XMODEM) &&
                out_result_q[31:16] != 16'h0000,
                "16-bit crc with upper bits set")

endmodule

`default_nettype wire

FILE: dv/multi_mode_crc_checker_core_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// multi_mode_crc_checker_core_tb
// drives byte messages in every crc mode through the checker and compares
// each finished crc and match flag against an in-bench crc calculator;
// both handshakes idle at random, config is rewritten between phases
// ---------------------------------------------------------------------------

module multi_mode_crc_checker_core_tb;

  localparam int RANDOM_BYTES = 1750;
  localparam int CYCLE_LIMIT  = 500000;
  localparam int QUIET_CYCLES = 4;
  localparam int DRAIN_CYCLES = 8;

  localparam logic [1:0] MODE_SPARE   = 2'd3;
  localparam logic [1:0] CFG_SPARE_LO = 2'd2;
  localparam logic [1:0] CFG_SPARE_HI = 2'd3;

  typedef struct packed {
    logic [31:0] crc;
    logic        match;
  } crc_out_t;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [1:0]  cfg_index_i;
  logic [15:0] cfg_wdata_i;

  mmcrc_in_if  in_ch ();
  mmcrc_out_if out_ch ();

  multi_mode_crc_checker_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always #6 clk_i = ~clk_i;

  // calculator state, mirrors the block's settings and running remainder
  logic [1:0]  calc_mode;
  logic [15:0] calc_seed;
  logic [31:0] calc_rem;

  crc_out_t pending_results[$];
  crc_out_t oldest_crc;
  int       mismatches = 0;
  int       bytes_sent = 0;
  int       cycle_count = 0;
  int       in_burst_left = 0;
  int       out_burst_left = 0;

  function automatic logic [31:0] crc_byte_step(input logic [1:0] mode,
                                                input logic [31:0] rem,
                                                input logic [7:0] b);
    logic [31:0] r;
    case (mode)
      mmcrc_pkg::MODE_CRC16_SEEDED: begin
        r = {16'h0000, rem[15:0] ^ {8'h00, b}};
        for (int i = 0; i < 8; i++)
          r = (r >> 1) ^ (r[0] ? {16'h0000, mmcrc_pkg::POLY16_REFL} : 32'h0);
      end
      mmcrc_pkg::MODE_XMODEM: begin
        r = {16'h0000, rem[15:0] ^ {b, 8'h00}};
        for (int i = 0; i < 8; i++)
          r = {16'h0000, r[14:0], 1'b0} ^ (r[15] ? {16'h0000, mmcrc_pkg::POLY16} : 32'h0);
      end
      default: begin
        // spare mode value runs as crc-32
        r = rem ^ {24'h000000, b};
        for (int i = 0; i < 8; i++) r = (r >> 1) ^ (r[0] ? mmcrc_pkg::POLY32_REFL : 32'h0);
      end
    endcase
    return r;
  endfunction

  function automatic logic [31:0] crc_finish(input logic [1:0] mode, input logic [31:0] rem);
    case (mode)
      mmcrc_pkg::MODE_CRC16_SEEDED: return {16'h0000, rem[15:0] ^ mmcrc_pkg::XOR16};
      mmcrc_pkg::MODE_XMODEM:       return {16'h0000, rem[15:0]};
      default:                      return rem ^ mmcrc_pkg::XOR32;
    endcase
  endfunction

  function automatic logic [31:0] crc_start();
    case (calc_mode)
      mmcrc_pkg::MODE_CRC16_SEEDED: return {16'h0000, calc_seed};
      mmcrc_pkg::MODE_XMODEM:       return 32'h0;
      default:                      return mmcrc_pkg::XOR32;
    endcase
  endfunction

  function automatic logic narrow_mode();
    return calc_mode == mmcrc_pkg::MODE_CRC16_SEEDED || calc_mode == mmcrc_pkg::MODE_XMODEM;
  endfunction

  function automatic logic [31:0] message_crc(input logic [7:0] msg[$]);
    logic [31:0] r;
    r = crc_start();
    foreach (msg[i]) r = crc_byte_step(calc_mode, r, msg[i]);
    return crc_finish(calc_mode, r);
  endfunction

  // wait before the next item, with occasional stretches of back-to-back items
  function automatic int draw_wait(inout int burst_left);
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    if ($urandom_range(0, 9) == 0) begin
      burst_left = $urandom_range(20, 60);
      return 0;
    end
    return $urandom_range(0, 19);
  endfunction

  task automatic predict_byte(input logic [7:0] b, input logic last, input logic [31:0] check);
    crc_out_t    res;
    logic [31:0] cmp;
    calc_rem = crc_byte_step(calc_mode, calc_rem, b);
    if (last) begin
      res.crc   = crc_finish(calc_mode, calc_rem);
      cmp       = narrow_mode() ? {16'h0000, check[15:0]} : check;
      res.match = (res.crc == cmp);
      pending_results.push_back(res);
      calc_rem = crc_start();
    end
  endtask

  task automatic send_byte(input logic [7:0] b, input logic last, input logic [31:0] check);
    int gap;
    gap = draw_wait(in_burst_left);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid     <= 1'b1;
    in_ch.data_byte <= b;
    in_ch.last_byte <= last;
    in_ch.crc_check <= check;
    do @(posedge clk_i); while (!in_ch.ready);
    predict_byte(b, last, check);
    bytes_sent++;
  endtask

  task automatic send_message(input logic [7:0] msg[$], input logic [31:0] check);
    foreach (msg[i]) begin
      if (i == msg.size() - 1) send_byte(msg[i], 1'b1, check);
      else send_byte(msg[i], 1'b0, $urandom());
    end
  endtask

  task automatic send_good(input logic [7:0] msg[$]);
    send_message(msg, message_crc(msg));
  endtask

  // stop sending and let results and trailing non-last items settle
  task automatic wait_quiet();
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (QUIET_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] data);
    wait_quiet();
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    case (idx)
      mmcrc_pkg::CFG_MODE: calc_mode = data[1:0];
      mmcrc_pkg::CFG_SEED: calc_seed = data;
      default: ;
    endcase
    if (idx == mmcrc_pkg::CFG_MODE || idx == mmcrc_pkg::CFG_SEED) calc_rem = crc_start();
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic write_random_mode();
    logic [15:0] data;
    data = ($urandom_range(0, 1) == 0) ? 16'($urandom()) : 16'h0000;
    data[1:0] = 2'($urandom_range(mmcrc_pkg::MODE_CRC16_SEEDED, MODE_SPARE));
    write_reg(mmcrc_pkg::CFG_MODE, data);
  endtask

  task automatic write_random_seed();
    case ($urandom_range(0, 3))
      0:       write_reg(mmcrc_pkg::CFG_SEED, 16'h0000);
      1:       write_reg(mmcrc_pkg::CFG_SEED, 16'hFFFF);
      2:       write_reg(mmcrc_pkg::CFG_SEED, 16'hCDB4);
      default: write_reg(mmcrc_pkg::CFG_SEED, 16'($urandom()));
    endcase
  endtask

  task automatic send_random_message();
    logic [7:0]  msg[$];
    logic [31:0] good;
    logic [31:0] check;
    int          len;
    int          pick;
    len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
    repeat (len) msg.push_back(8'($urandom()));
    good = message_crc(msg);
    pick = $urandom_range(0, 9);
    if (pick < 6) begin
      check = good;
      // 16-bit modes must ignore the upper half
      if (narrow_mode()) check[31:16] = 16'($urandom());
    end else if (pick < 8) begin
      check = good ^ (32'h1 << $urandom_range(0, narrow_mode() ? 15 : 31));
    end else begin
      check = $urandom();
    end
    send_message(msg, check);
  endtask

  task automatic test_crc16_seeded_defaults();
    logic [7:0] msg[$];
    msg = '{8'h00, 8'hFF};
    send_good(msg);
    msg = '{8'hFF};
    send_message(msg, 32'hFFFF_FFFF);
  endtask

  task automatic test_xmodem();
    logic [7:0] msg[$];
    write_reg(mmcrc_pkg::CFG_MODE, {14'h0000, mmcrc_pkg::MODE_XMODEM});
    msg = '{8'h00};
    send_message(msg, 32'h0000_0000);
    msg = '{8'hFF, 8'h31};
    send_good(msg);
  endtask

  task automatic test_crc32();
    logic [7:0] msg[$];
    write_reg(mmcrc_pkg::CFG_MODE, {14'h0000, mmcrc_pkg::MODE_CRC32});
    msg = '{8'hFF};
    send_message(msg, 32'hFFFF_FFFF);
    msg = '{8'h00, 8'h80};
    send_good(msg);
  endtask

  task automatic test_unused_mode();
    logic [7:0] msg[$];
    write_reg(mmcrc_pkg::CFG_MODE, {14'h0000, MODE_SPARE});
    msg = '{8'hA5};
    send_good(msg);
  endtask

  task automatic test_address_mark();
    logic [7:0] msg[$];
    write_reg(mmcrc_pkg::CFG_MODE, {14'h0000, mmcrc_pkg::MODE_CRC16_SEEDED});
    write_reg(mmcrc_pkg::CFG_SEED, 16'hCDB4);
    msg = '{8'hFE, 8'h01, 8'h02};
    send_good(msg);
    write_reg(mmcrc_pkg::CFG_SEED, 16'h0000);
    msg = '{8'h00};
    send_good(msg);
  endtask

  task automatic test_write_abandons_message();
    logic [7:0] msg[$];
    send_byte(8'h12, 1'b0, $urandom());
    send_byte(8'h34, 1'b0, $urandom());
    write_reg(mmcrc_pkg::CFG_SEED, 16'hFFFF);
    msg = '{8'h56};
    send_good(msg);
  endtask

  task automatic test_unused_register_index();
    send_byte(8'h9A, 1'b0, 32'h0000_0000);
    // writes past the register list must not reload the remainder
    write_reg(CFG_SPARE_LO, 16'hFFFF);
    write_reg(CFG_SPARE_HI, 16'h0000);
    send_byte(8'hBC, 1'b1, crc_finish(calc_mode, crc_byte_step(calc_mode, calc_rem, 8'hBC)));
  endtask

  task automatic test_random_traffic();
    int first;
    int pick;
    first = bytes_sent;
    while (bytes_sent - first < RANDOM_BYTES) begin
      pick = $urandom_range(0, 99);
      if (pick < 4) begin
        write_random_mode();
        write_random_seed();
      end else if (pick < 6) begin
        repeat ($urandom_range(1, 5)) send_byte(8'($urandom()), 1'b0, $urandom());
        if ($urandom_range(0, 1) == 0) write_random_mode();
        else write_random_seed();
      end else if (pick < 8) begin
        if ($urandom_range(0, 1) == 0) send_byte(8'($urandom()), 1'b0, $urandom());
        write_reg($urandom_range(0, 1) == 0 ? CFG_SPARE_LO : CFG_SPARE_HI, 16'($urandom()));
      end else begin
        send_random_message();
      end
    end
  endtask

  initial begin
    rst_ni          <= 1'b0;
    cfg_we_i        <= 1'b0;
    cfg_index_i     <= mmcrc_pkg::CFG_MODE;
    cfg_wdata_i     <= 16'h0000;
    in_ch.valid     <= 1'b0;
    in_ch.data_byte <= 8'h00;
    in_ch.last_byte <= 1'b0;
    in_ch.crc_check <= 32'h0;
    calc_mode = mmcrc_pkg::MODE_CRC16_SEEDED;
    calc_seed = mmcrc_pkg::SEED_RESET;
    calc_rem  = crc_start();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_crc16_seeded_defaults();
    test_xmodem();
    test_crc32();
    test_unused_mode();
    test_address_mark();
    test_write_abandons_message();
    test_unused_register_index();
    test_random_traffic();

    wait_quiet();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // result side: random stalls per item
  initial begin
    int stall;
    out_ch.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      stall = draw_wait(out_burst_left);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk_i); while (!out_ch.valid);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni === 1'b1 && out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected item crc_result %h crc_match %b", $time,
                 out_ch.crc_result, out_ch.crc_match);
        mismatches++;
      end else begin
        oldest_crc = pending_results.pop_front();
        if (out_ch.crc_result !== oldest_crc.crc) begin
          $display("%0t: crc_result expected %h actual %h", $time,
                   oldest_crc.crc, out_ch.crc_result);
          mismatches++;
        end
        if (out_ch.crc_match !== oldest_crc.match) begin
          $display("%0t: crc_match expected %b actual %b", $time,
                   oldest_crc.match, out_ch.crc_match);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

endmodule
